@@ rtl/core/sbkd_pkg.sv @@
// Shared types, widths and helper functions for the spectral bin Kalman denoiser.
// No dependencies; used by the top level and its checker.
`default_nettype none

package sbkd_pkg;

  // Field widths fixed by the item format
  localparam int IDX_W      = 12;
  localparam int COEF_W     = 24;
  localparam int VAR_W      = 48;
  localparam int RATIO_W    = 16;
  localparam int RATIO_FRAC = 8;
  localparam int GAIN_FRAC  = 16;
  localparam int BINS_DEF   = 4096;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NONE    = 2'd3;
  localparam logic [RATIO_W-1:0]   RATIO_RESET = 16'd1024;

  // Derived arithmetic widths
  localparam int G_W    = GAIN_FRAC + 1;       // gain in [0, 1.0]
  localparam int Q_W    = GAIN_FRAC + 1;       // raw quotient bits
  localparam int DEN_W  = VAR_W + 1;
  localparam int REM_W  = VAR_W + 2;
  localparam int AD_W   = COEF_W + 1;
  localparam int SQ_W   = 2 * AD_W;
  localparam int NR_W   = VAR_W + RATIO_W;
  localparam int HALF_W = VAR_W / 2;
  localparam int T_W    = COEF_W + G_W + 1;
  localparam int ES_W   = G_W + HALF_W;
  localparam int E_W    = G_W + VAR_W + 1;
  localparam int GG_W   = 2 * G_W;
  localparam int PP_W   = GG_W + HALF_W;
  localparam int P_W    = GG_W + VAR_W + 1;

  localparam logic [G_W-1:0] GAIN_ONE = G_W'(1) << GAIN_FRAC;

  typedef struct packed {
    logic [IDX_W-1:0]         bin_index;
    logic signed [COEF_W-1:0] cur_re;
    logic signed [COEF_W-1:0] cur_im;
    logic [VAR_W-1:0]         pattern_noise;
    logic                     restart;
  } sbkd_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_index;
    logic signed [COEF_W-1:0] est_re;
    logic signed [COEF_W-1:0] est_im;
    logic                     motion_reset;
  } sbkd_out_t;

  // One memory word: full per-bin state
  typedef struct packed {
    logic signed [COEF_W-1:0] last_re;
    logic signed [COEF_W-1:0] last_im;
    logic [VAR_W-1:0]         err_re;
    logic [VAR_W-1:0]         err_im;
    logic [VAR_W-1:0]         proc_re;
    logic [VAR_W-1:0]         proc_im;
  } sbkd_state_t;

  // Per-item tag that rides along every stage
  typedef struct packed {
    logic [IDX_W-1:0] bin;
    logic [VAR_W-1:0] noise;
    logic             rst;
  } sbkd_tag_t;

  // One component through the divider stages
  typedef struct packed {
    logic signed [COEF_W-1:0] cur;
    logic signed [COEF_W-1:0] last;
    logic [VAR_W-1:0]         sum;
    logic [DEN_W-1:0]         den;
    logic [REM_W-1:0]         rem;
    logic [Q_W-1:0]           q;
  } sbkd_lane_t;

  // One component after the first multiply stage
  typedef struct packed {
    logic signed [COEF_W-1:0] cur;
    logic [GG_W-1:0]          gg;
    logic signed [T_W-1:0]    gcur;
    logic signed [T_W-1:0]    olast;
    logic [ES_W-1:0]          es_lo;
    logic [ES_W-1:0]          es_hi;
  } sbkd_m1_t;

  // One component after the second multiply stage
  typedef struct packed {
    logic signed [COEF_W-1:0] cur;
    logic signed [COEF_W-1:0] est;
    logic [VAR_W-1:0]         err;
    logic [PP_W-1:0]          pp_lo;
    logic [PP_W-1:0]          pp_hi;
  } sbkd_m2_t;

  // Saturating sum of error and process variance
  function automatic logic [VAR_W-1:0] sat_sum(input logic [VAR_W-1:0] a,
                                               input logic [VAR_W-1:0] b);
    logic [VAR_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      sat_sum = s[VAR_W] ? {VAR_W{1'b1}} : s[VAR_W-1:0];
    end
  endfunction

  // One restoring division step: shift, compare, subtract
  function automatic sbkd_lane_t div_step(input sbkd_lane_t l);
    sbkd_lane_t     r;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] den_x;
    begin
      r     = l;
      rem2  = {l.rem[REM_W-2:0], 1'b0};
      den_x = REM_W'(l.den);
      if (rem2 >= den_x) begin
        r.rem = rem2 - den_x;
        r.q   = {l.q[Q_W-2:0], 1'b1};
      end else begin
        r.rem = rem2;
        r.q   = {l.q[Q_W-2:0], 1'b0};
      end
      div_step = r;
    end
  endfunction

  // Rounded gain from the raw quotient; zero noise gives full or no gain
  function automatic logic [G_W-1:0] gain_of(input logic [VAR_W-1:0] sum,
                                             input logic [Q_W-1:0]   q,
                                             input logic [VAR_W-1:0] noise);
    logic [Q_W:0] qr;
    begin
      qr = {1'b0, q} + (Q_W+1)'(1);
      if (noise == '0) begin
        gain_of = (sum != '0) ? GAIN_ONE : '0;
      end else begin
        gain_of = qr[Q_W:1];
      end
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/spectral_bin_kalman_denoiser.sv @@
// Top level of the spectral bin Kalman denoiser: state memory and full datapath.
// Depends on sbkd_pkg for item types, widths and arithmetic helpers.
//
// Usage:
//   in channel (in_valid / in_stall / in_data) takes one complex bin per request.
//   out channel (out_valid / out_stall / out_data) returns one estimate per request,
//   in order. Configuration is a plain write port (cfg_we, cfg_index, cfg_data);
//   write it only while no request is in flight.
// Pipeline: memory read, motion test, an 18-stage gain divider (setup, then one
//   quotient bit per stage), multiply stages and a final rounding stage.
// Throughput: one request per cycle while no result is held. A request whose bin
//   matches one still in the pipeline waits until that one has written its state
//   back, so the per-bin memory read-modify-write loop limits how often the same
//   bin can be taken.
// Reset: clears all valid bits and returns the configuration registers to their
//   reset values. The state memory is not cleared: send restart with the first frame of every bin.
// Stall: while out_stall holds a waiting result, the whole pipeline holds and
//   in_stall is raised; nothing is dropped or repeated.
// BINS must be a power of two; bin indexes wrap modulo BINS.
`default_nettype none

module spectral_bin_kalman_denoiser #(
  parameter int BINS = sbkd_pkg::BINS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire sbkd_pkg::sbkd_in_t                in_data,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      sbkd_pkg::sbkd_out_t               out_data,
  input  wire logic                              cfg_we,
  input  wire logic [sbkd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sbkd_pkg::VAR_W-1:0]        cfg_data
);

  localparam int AW    = $clog2(BINS);
  localparam int DIV_N = sbkd_pkg::Q_W + 1;
  localparam int CW    = sbkd_pkg::COEF_W;
  localparam int VW    = sbkd_pkg::VAR_W;
  localparam int GF    = sbkd_pkg::GAIN_FRAC;
  localparam int HW    = sbkd_pkg::HALF_W;

  // Configuration registers
  logic [VW-1:0]                     noise_variance;
  logic                              use_pattern;
  logic [sbkd_pkg::RATIO_W-1:0]      motion_ratio_sq;

  // Pipeline control
  logic          adv;
  logic          hazard;
  logic          in_acc;
  logic [AW-1:0] in_addr;

  // Entry stage (memory read data lands here)
  logic                     e_v;
  sbkd_pkg::sbkd_tag_t      e_tag;
  logic signed [CW-1:0]     e_cur_re, e_cur_im;
  sbkd_pkg::sbkd_state_t    rd_q;

  // Stage A: absolute differences and sums
  logic                        a_v;
  sbkd_pkg::sbkd_tag_t         a_tag;
  sbkd_pkg::sbkd_lane_t        a_re, a_im;
  logic [sbkd_pkg::AD_W-1:0]   a_ad_re, a_ad_im;

  // Stage B: squares, threshold product, divider setup
  logic                        b_v;
  sbkd_pkg::sbkd_tag_t         b_tag;
  sbkd_pkg::sbkd_lane_t        b_re, b_im;
  logic [sbkd_pkg::SQ_W-1:0]   b_sq_re, b_sq_im;
  logic [sbkd_pkg::NR_W-1:0]   b_nr;

  // Divider stages
  logic                 d_v   [DIV_N];
  sbkd_pkg::sbkd_tag_t  d_tag [DIV_N];
  sbkd_pkg::sbkd_lane_t d_re  [DIV_N];
  sbkd_pkg::sbkd_lane_t d_im  [DIV_N];

  // Multiply stages
  logic                 m1_v, m2_v;
  sbkd_pkg::sbkd_tag_t  m1_tag, m2_tag;
  sbkd_pkg::sbkd_m1_t   m1_re, m1_im;
  sbkd_pkg::sbkd_m2_t   m2_re, m2_im;

  // Combinational results between stages
  logic                        moved_b;
  sbkd_pkg::sbkd_lane_t        a_re_next, a_im_next;
  logic [sbkd_pkg::AD_W-1:0]   ad_re_next, ad_im_next;
  logic [sbkd_pkg::DEN_W-1:0]  den_re_next, den_im_next;
  sbkd_pkg::sbkd_lane_t        b_re_next, b_im_next;
  sbkd_pkg::sbkd_tag_t         d0_tag_next;
  sbkd_pkg::sbkd_m1_t          m1_re_next, m1_im_next;
  sbkd_pkg::sbkd_m2_t          m2_re_next, m2_im_next;

  // State write-back
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  sbkd_pkg::sbkd_state_t  wr_data;
  logic [VW-1:0]          proc_re_fin, proc_im_fin;

  sbkd_pkg::sbkd_state_t  mem [BINS];

  // Write configuration; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_variance  <= '0;
      use_pattern     <= 1'b0;
      motion_ratio_sq <= sbkd_pkg::RATIO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbkd_pkg::REG_NOISE:   noise_variance  <= cfg_data;
        sbkd_pkg::REG_PATTERN: use_pattern     <= cfg_data[0];
        sbkd_pkg::REG_RATIO:   motion_ratio_sq <= cfg_data[sbkd_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless a finished result is held
  assign adv     = !out_valid || !out_stall;
  assign in_addr = AW'(in_data.bin_index);
  assign in_stall = !adv || hazard;
  assign in_acc  = in_valid && !in_stall;

  // Hold a request whose bin is still in flight
  always_comb begin
    hazard = 1'b0;
    if (e_v  && AW'(e_tag.bin)  == in_addr) hazard = 1'b1;
    if (a_v  && AW'(a_tag.bin)  == in_addr) hazard = 1'b1;
    if (b_v  && AW'(b_tag.bin)  == in_addr) hazard = 1'b1;
    if (m1_v && AW'(m1_tag.bin) == in_addr) hazard = 1'b1;
    if (m2_v && AW'(m2_tag.bin) == in_addr) hazard = 1'b1;
    for (int k = 0; k < DIV_N; k++) begin
      if (d_v[k] && AW'(d_tag[k].bin) == in_addr) hazard = 1'b1;
    end
  end

  // State memory: read at accept, write when a result leaves the last stage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (adv) begin
      rd_q <= mem[in_addr];
    end
  end

  // Stage A logic: differences and saturated variance sums
  always_comb begin
    logic signed [CW:0] dre, dim;
    dre = (CW+1)'(e_cur_re) - (CW+1)'(rd_q.last_re);
    dim = (CW+1)'(e_cur_im) - (CW+1)'(rd_q.last_im);
    ad_re_next = dre[CW] ? sbkd_pkg::AD_W'(-dre) : sbkd_pkg::AD_W'(dre);
    ad_im_next = dim[CW] ? sbkd_pkg::AD_W'(-dim) : sbkd_pkg::AD_W'(dim);
    a_re_next = '0;
    a_im_next = '0;
    a_re_next.cur  = e_cur_re;
    a_re_next.last = rd_q.last_re;
    a_re_next.sum  = sbkd_pkg::sat_sum(rd_q.err_re, rd_q.proc_re);
    a_im_next.cur  = e_cur_im;
    a_im_next.last = rd_q.last_im;
    a_im_next.sum  = sbkd_pkg::sat_sum(rd_q.err_im, rd_q.proc_im);
  end

  // Stage B logic: divisor for the gain
  assign den_re_next = {1'b0, a_re.sum} + {1'b0, a_tag.noise};
  assign den_im_next = {1'b0, a_im.sum} + {1'b0, a_tag.noise};

  // Set up both divider lanes
  always_comb begin
    b_re_next     = a_re;
    b_re_next.den = den_re_next;
    b_re_next.rem = sbkd_pkg::REM_W'(a_re.sum);
    b_re_next.q   = '0;
    b_im_next     = a_im;
    b_im_next.den = den_im_next;
    b_im_next.rem = sbkd_pkg::REM_W'(a_im.sum);
    b_im_next.q   = '0;
  end

  // Motion test ahead of the divider
  assign moved_b = (sbkd_pkg::NR_W'({b_sq_re, {sbkd_pkg::RATIO_FRAC{1'b0}}}) > b_nr)
                || (sbkd_pkg::NR_W'({b_sq_im, {sbkd_pkg::RATIO_FRAC{1'b0}}}) > b_nr);

  // Fold the motion result into the reset flag
  always_comb begin
    d0_tag_next     = b_tag;
    d0_tag_next.rst = b_tag.rst || moved_b;
  end

  // First multiply stage: gain, its square and the weighted terms
  always_comb begin
    logic [sbkd_pkg::G_W-1:0] g_re, g_im, om_re, om_im;
    sbkd_pkg::sbkd_lane_t     lr, li;
    lr    = d_re[DIV_N-1];
    li    = d_im[DIV_N-1];
    g_re  = sbkd_pkg::gain_of(lr.sum, lr.q, d_tag[DIV_N-1].noise);
    g_im  = sbkd_pkg::gain_of(li.sum, li.q, d_tag[DIV_N-1].noise);
    om_re = sbkd_pkg::GAIN_ONE - g_re;
    om_im = sbkd_pkg::GAIN_ONE - g_im;
    m1_re_next.cur   = lr.cur;
    m1_re_next.gg    = sbkd_pkg::GG_W'(g_re) * sbkd_pkg::GG_W'(g_re);
    m1_re_next.gcur  = sbkd_pkg::T_W'($signed({1'b0, g_re})) * sbkd_pkg::T_W'(lr.cur);
    m1_re_next.olast = sbkd_pkg::T_W'($signed({1'b0, om_re})) * sbkd_pkg::T_W'(lr.last);
    m1_re_next.es_lo = sbkd_pkg::ES_W'(om_re) * sbkd_pkg::ES_W'(lr.sum[HW-1:0]);
    m1_re_next.es_hi = sbkd_pkg::ES_W'(om_re) * sbkd_pkg::ES_W'(lr.sum[VW-1:HW]);
    m1_im_next.cur   = li.cur;
    m1_im_next.gg    = sbkd_pkg::GG_W'(g_im) * sbkd_pkg::GG_W'(g_im);
    m1_im_next.gcur  = sbkd_pkg::T_W'($signed({1'b0, g_im})) * sbkd_pkg::T_W'(li.cur);
    m1_im_next.olast = sbkd_pkg::T_W'($signed({1'b0, om_im})) * sbkd_pkg::T_W'(li.last);
    m1_im_next.es_lo = sbkd_pkg::ES_W'(om_im) * sbkd_pkg::ES_W'(li.sum[HW-1:0]);
    m1_im_next.es_hi = sbkd_pkg::ES_W'(om_im) * sbkd_pkg::ES_W'(li.sum[VW-1:HW]);
  end

  // Second multiply stage: round estimate and error, split process product
  always_comb begin
    logic signed [sbkd_pkg::T_W-1:0] t_re, t_im;
    logic [sbkd_pkg::E_W-1:0]        e_re, e_im;
    t_re = m1_re.gcur + m1_re.olast + sbkd_pkg::T_W'(1 << (GF - 1));
    t_im = m1_im.gcur + m1_im.olast + sbkd_pkg::T_W'(1 << (GF - 1));
    e_re = sbkd_pkg::E_W'(m1_re.es_lo) + (sbkd_pkg::E_W'(m1_re.es_hi) << HW)
         + sbkd_pkg::E_W'(1 << (GF - 1));
    e_im = sbkd_pkg::E_W'(m1_im.es_lo) + (sbkd_pkg::E_W'(m1_im.es_hi) << HW)
         + sbkd_pkg::E_W'(1 << (GF - 1));
    m2_re_next.cur   = m1_re.cur;
    m2_re_next.est   = t_re[GF +: CW];
    m2_re_next.err   = e_re[GF +: VW];
    m2_re_next.pp_lo = sbkd_pkg::PP_W'(m1_re.gg) * sbkd_pkg::PP_W'(m1_tag.noise[HW-1:0]);
    m2_re_next.pp_hi = sbkd_pkg::PP_W'(m1_re.gg) * sbkd_pkg::PP_W'(m1_tag.noise[VW-1:HW]);
    m2_im_next.cur   = m1_im.cur;
    m2_im_next.est   = t_im[GF +: CW];
    m2_im_next.err   = e_im[GF +: VW];
    m2_im_next.pp_lo = sbkd_pkg::PP_W'(m1_im.gg) * sbkd_pkg::PP_W'(m1_tag.noise[HW-1:0]);
    m2_im_next.pp_hi = sbkd_pkg::PP_W'(m1_im.gg) * sbkd_pkg::PP_W'(m1_tag.noise[VW-1:HW]);
  end

  // Final stage: round process variance, pick reset or update branch
  always_comb begin
    logic [sbkd_pkg::P_W-1:0] p_re, p_im;
    p_re = sbkd_pkg::P_W'(m2_re.pp_lo) + (sbkd_pkg::P_W'(m2_re.pp_hi) << HW)
         + (sbkd_pkg::P_W'(1) << (2 * GF - 1));
    p_im = sbkd_pkg::P_W'(m2_im.pp_lo) + (sbkd_pkg::P_W'(m2_im.pp_hi) << HW)
         + (sbkd_pkg::P_W'(1) << (2 * GF - 1));
    proc_re_fin = p_re[2 * GF +: VW];
    proc_im_fin = p_im[2 * GF +: VW];
    if (m2_tag.rst) begin
      wr_data.last_re = m2_re.cur;
      wr_data.last_im = m2_im.cur;
      wr_data.err_re  = m2_tag.noise;
      wr_data.err_im  = m2_tag.noise;
      wr_data.proc_re = m2_tag.noise;
      wr_data.proc_im = m2_tag.noise;
    end else begin
      wr_data.last_re = m2_re.est;
      wr_data.last_im = m2_im.est;
      wr_data.err_re  = m2_re.err;
      wr_data.err_im  = m2_im.err;
      wr_data.proc_re = proc_re_fin;
      wr_data.proc_im = proc_im_fin;
    end
  end

  assign wr_en   = adv && m2_v;
  assign wr_addr = AW'(m2_tag.bin);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      e_v       <= 1'b0;
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      m1_v      <= 1'b0;
      m2_v      <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < DIV_N; k++) begin
        d_v[k] <= 1'b0;
      end
    end else if (adv) begin
      e_v       <= in_acc;
      a_v       <= e_v;
      b_v       <= a_v;
      d_v[0]    <= b_v;
      for (int k = 1; k < DIV_N; k++) begin
        d_v[k] <= d_v[k-1];
      end
      m1_v      <= d_v[DIV_N-1];
      m2_v      <= m1_v;
      out_valid <= m2_v;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      e_tag.bin   <= in_data.bin_index;
      e_tag.noise <= use_pattern ? in_data.pattern_noise : noise_variance;
      e_tag.rst   <= in_data.restart;
      e_cur_re    <= in_data.cur_re;
      e_cur_im    <= in_data.cur_im;

      a_tag   <= e_tag;
      a_re    <= a_re_next;
      a_im    <= a_im_next;
      a_ad_re <= ad_re_next;
      a_ad_im <= ad_im_next;

      b_tag      <= a_tag;
      b_re       <= b_re_next;
      b_im       <= b_im_next;
      b_sq_re    <= sbkd_pkg::SQ_W'(a_ad_re) * sbkd_pkg::SQ_W'(a_ad_re);
      b_sq_im    <= sbkd_pkg::SQ_W'(a_ad_im) * sbkd_pkg::SQ_W'(a_ad_im);
      b_nr       <= sbkd_pkg::NR_W'(a_tag.noise) * sbkd_pkg::NR_W'(motion_ratio_sq);

      d_tag[0]     <= d0_tag_next;
      d_re[0]      <= b_re;
      d_im[0]      <= b_im;
      for (int k = 1; k < DIV_N; k++) begin
        d_tag[k] <= d_tag[k-1];
        d_re[k]  <= sbkd_pkg::div_step(d_re[k-1]);
        d_im[k]  <= sbkd_pkg::div_step(d_im[k-1]);
      end

      m1_tag <= d_tag[DIV_N-1];
      m1_re  <= m1_re_next;
      m1_im  <= m1_im_next;

      m2_tag <= m1_tag;
      m2_re  <= m2_re_next;
      m2_im  <= m2_im_next;

      out_data.out_index    <= m2_tag.bin;
      out_data.est_re       <= wr_data.last_re;
      out_data.est_im       <= wr_data.last_im;
      out_data.motion_reset <= m2_tag.rst;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sbkd_checker.sv @@
// Port-level checker for the spectral bin Kalman denoiser, bound to the top level.
// Depends on sbkd_pkg for the result type.
`default_nettype none

module sbkd_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire sbkd_pkg::sbkd_out_t out_data
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

  // No result right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A held result freezes the pipeline, so no request may enter
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("request taken while output held");

  // Out of reset the result valid is always a known level
  a_valid_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(out_valid))
    else $error("result valid unknown");

endmodule

bind spectral_bin_kalman_denoiser sbkd_checker u_sbkd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
